@@ design/bit_matrix_rect_rotate_display_macros.svh @@
// Assertion macros for the bit matrix display checker.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef BIT_MATRIX_RECT_ROTATE_DISPLAY_MACROS_SVH
`define BIT_MATRIX_RECT_ROTATE_DISPLAY_MACROS_SVH

// Check a consequent in the same cycle as its antecedent.
`define BMRD_CHK_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define BMRD_CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/bmrd_pkg.sv @@
`timescale 1ns / 1ps

package bmrd_pkg;

  // Matrix geometry
  localparam int ROWS = 6;
  localparam int COLS = 50;

  // Field widths
  localparam int MODE_W     = 2;
  localparam int A_W        = 6;
  localparam int B_W        = 8;
  localparam int ROW_BITS_W = 50;
  localparam int LIT_W      = 9;

  // Derived index and counter widths
  localparam int ROW_W      = $clog2(ROWS);
  localparam int COL_IDX_W  = $clog2(COLS);
  localparam int HALF       = (COLS + 1) / 2;
  localparam int HALF_CNT_W = $clog2(HALF + 1);

  typedef enum logic [MODE_W-1:0] {
    MODE_RECT = 2'd0,
    MODE_ROW  = 2'd1,
    MODE_COL  = 2'd2,
    MODE_READ = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD,
    S_FILL,
    S_ROT,
    S_COUNT,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    ST_HOLD,
    ST_FILL,
    ST_ROT_ROW,
    ST_ROT_COL
  } store_op_t;

  typedef struct packed {
    store_op_t            op;
    logic [ROW_W-1:0]     row;
    logic [COL_IDX_W-1:0] col;
    logic [A_W-1:0]       width;
  } store_ctl_t;

  typedef struct packed {
    logic clear;
    logic add;
    logic half;
  } count_ctl_t;

endpackage

@@ design/bit_matrix_rect_rotate_display.sv @@
`timescale 1ns / 1ps
// Sequence: after accept, a rect fills its rows (clamped to the matrix height), a rotation
//   reduces its shift by the modulus, makes one final compare and then takes any unit rotation
//   steps left; every item then sweeps the half rows to count lit pixels, and the result is loaded.
// Throughput: one item at a time, the next accepted in the cycle after the result is loaded;
//   a result still waiting on out_ready holds off the load.
// Reset: synchronous active-low rst_n darkens all pixels at once and empties the output.
module bit_matrix_rect_rotate_display (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [bmrd_pkg::MODE_W-1:0]       in_mode,
  input  logic [bmrd_pkg::A_W-1:0]          in_arg_a,
  input  logic [bmrd_pkg::B_W-1:0]          in_arg_b,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [bmrd_pkg::ROW_BITS_W-1:0]   out_row_bits,
  output logic [bmrd_pkg::LIT_W-1:0]        out_lit_count,
  output logic                              out_bad_index
);

  bmrd_pkg::store_ctl_t              store_ctl;
  bmrd_pkg::count_ctl_t              count_ctl;
  logic [bmrd_pkg::COLS-1:0]         rd_row;
  logic [bmrd_pkg::LIT_W-1:0]        count;
  logic                              out_free;
  logic                              out_load;
  logic                              bad;

  logic                              out_valid_r;
  logic [bmrd_pkg::ROW_BITS_W-1:0]   out_row_bits_r;
  logic [bmrd_pkg::LIT_W-1:0]        out_lit_count_r;
  logic                              out_bad_index_r;

  assign out_free = !out_valid_r || out_ready;

  bmrd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_mode   (in_mode),
    .in_arg_a  (in_arg_a),
    .in_arg_b  (in_arg_b),
    .out_free  (out_free),
    .in_ready  (in_ready),
    .out_load  (out_load),
    .bad       (bad),
    .store_ctl (store_ctl),
    .count_ctl (count_ctl)
  );

  bmrd_store u_store (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (store_ctl),
    .rd_row (rd_row)
  );

  bmrd_count u_count (
    .clk   (clk),
    .ctl   (count_ctl),
    .row   (rd_row),
    .count (count)
  );

  // Hold the result until it is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_row_bits_r  <= bad ? '0 : bmrd_pkg::ROW_BITS_W'(rd_row);
      out_lit_count_r <= count;
      out_bad_index_r <= bad;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_row_bits  = out_row_bits_r;
  assign out_lit_count = out_lit_count_r;
  assign out_bad_index = out_bad_index_r;

endmodule

@@ design/bmrd_store.sv @@
`timescale 1ns / 1ps

module bmrd_store (
  input  logic                       clk,
  input  logic                       rst_n,
  input  bmrd_pkg::store_ctl_t       ctl,
  output logic [bmrd_pkg::COLS-1:0]  rd_row
);

  logic [bmrd_pkg::COLS-1:0] rows_r   [bmrd_pkg::ROWS];
  logic [bmrd_pkg::COLS-1:0] rows_nxt [bmrd_pkg::ROWS];
  logic [bmrd_pkg::COLS-1:0] fill_mask;

  // Build the rect mask: columns below the width, clamped by the row length
  always_comb begin
    for (int j = 0; j < bmrd_pkg::COLS; j++) begin
      fill_mask[j] = (int'(ctl.width) > j);
    end
  end

  // Apply one step of the current operation
  always_comb begin
    int prev;
    prev = 0;
    for (int i = 0; i < bmrd_pkg::ROWS; i++) begin
      rows_nxt[i] = rows_r[i];
    end
    case (ctl.op)
      bmrd_pkg::ST_FILL: begin
        rows_nxt[ctl.row] = rows_r[ctl.row] | fill_mask;
      end
      bmrd_pkg::ST_ROT_ROW: begin
        rows_nxt[ctl.row] = {rows_r[ctl.row][bmrd_pkg::COLS-2:0],
                             rows_r[ctl.row][bmrd_pkg::COLS-1]};
      end
      bmrd_pkg::ST_ROT_COL: begin
        for (int i = 0; i < bmrd_pkg::ROWS; i++) begin
          prev = (i == 0) ? bmrd_pkg::ROWS - 1 : i - 1;
          rows_nxt[i][ctl.col] = rows_r[prev][ctl.col];
        end
      end
      default: begin
      end
    endcase
  end

  // Hold the pixels; reset darkens the whole matrix
  always_ff @(posedge clk) begin
    for (int i = 0; i < bmrd_pkg::ROWS; i++) begin
      if (!rst_n) begin
        rows_r[i] <= '0;
      end else begin
        rows_r[i] <= rows_nxt[i];
      end
    end
  end

  assign rd_row = rows_r[ctl.row];

endmodule

@@ design/bmrd_count.sv @@
`timescale 1ns / 1ps

module bmrd_count (
  input  logic                        clk,
  input  bmrd_pkg::count_ctl_t        ctl,
  input  logic [bmrd_pkg::COLS-1:0]   row,
  output logic [bmrd_pkg::LIT_W-1:0]  count
);

  logic [bmrd_pkg::COLS-1:0]       shifted;
  logic [bmrd_pkg::HALF-1:0]       chunk;
  logic [bmrd_pkg::HALF_CNT_W-1:0] chunk_sum;
  logic [bmrd_pkg::LIT_W-1:0]      count_r;
  logic [bmrd_pkg::LIT_W-1:0]      count_nxt;

  // Pick the lower or upper half of the row
  always_comb begin
    shifted = ctl.half ? (row >> bmrd_pkg::HALF) : row;
    chunk   = shifted[bmrd_pkg::HALF-1:0];
  end

  // Count the lit pixels of one half row
  always_comb begin
    chunk_sum = '0;
    for (int j = 0; j < bmrd_pkg::HALF; j++) begin
      chunk_sum = chunk_sum + bmrd_pkg::HALF_CNT_W'(chunk[j]);
    end
  end

  // Accumulate over the sweep
  always_comb begin
    count_nxt = count_r;
    if (ctl.clear) begin
      count_nxt = '0;
    end else if (ctl.add) begin
      count_nxt = count_r + bmrd_pkg::LIT_W'(chunk_sum);
    end
  end

  always_ff @(posedge clk) begin
    count_r <= count_nxt;
  end

  assign count = count_r;

endmodule

@@ design/bmrd_ctrl.sv @@
`timescale 1ns / 1ps

module bmrd_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [bmrd_pkg::MODE_W-1:0]   in_mode,
  input  logic [bmrd_pkg::A_W-1:0]      in_arg_a,
  input  logic [bmrd_pkg::B_W-1:0]      in_arg_b,
  input  logic                          out_free,
  output logic                          in_ready,
  output logic                          out_load,
  output logic                          bad,
  output bmrd_pkg::store_ctl_t          store_ctl,
  output bmrd_pkg::count_ctl_t          count_ctl
);

  bmrd_pkg::state_t          state_r, state_nxt;
  bmrd_pkg::mode_t           mode_r, mode_nxt;
  bmrd_pkg::mode_t           mode_in;
  logic [bmrd_pkg::A_W-1:0]  a_r, a_nxt;
  logic [bmrd_pkg::B_W-1:0]  amt_r, amt_nxt;
  logic                      bad_r, bad_nxt;
  logic [bmrd_pkg::ROW_W-1:0] row_r, row_nxt;
  logic                      half_r, half_nxt;

  logic                      bad_in;
  logic [bmrd_pkg::B_W-1:0]  sub_b;
  logic [bmrd_pkg::B_W-1:0]  diff;
  logic                      ge;
  logic                      fill_last;
  logic                      count_last;
  logic [bmrd_pkg::ROW_W-1:0] report_row;

  assign mode_in = bmrd_pkg::mode_t'(in_mode);

  // Flag an out-of-range index on the incoming item
  always_comb begin
    bad_in = 1'b0;
    unique case (mode_in) inside
      bmrd_pkg::MODE_ROW, bmrd_pkg::MODE_READ:
        bad_in = (int'(in_arg_a) >= bmrd_pkg::ROWS);
      bmrd_pkg::MODE_COL:
        bad_in = (int'(in_arg_a) >= bmrd_pkg::COLS);
      default:
        bad_in = 1'b0;
    endcase
  end

  // Shared subtractor: reduce the shift by the modulus, or count steps down by one
  always_comb begin
    if (state_r == bmrd_pkg::S_MOD) begin
      sub_b = (mode_r == bmrd_pkg::MODE_ROW) ? bmrd_pkg::B_W'(bmrd_pkg::COLS)
                                             : bmrd_pkg::B_W'(bmrd_pkg::ROWS);
    end else begin
      sub_b = bmrd_pkg::B_W'(1);
    end
    diff = amt_r - sub_b;
    ge   = (amt_r >= sub_b);
  end

  assign fill_last  = (row_r == bmrd_pkg::ROW_W'(bmrd_pkg::ROWS - 1)) ||
                      ((bmrd_pkg::B_W'(row_r) + bmrd_pkg::B_W'(1)) >= amt_r);
  assign count_last = (row_r == bmrd_pkg::ROW_W'(bmrd_pkg::ROWS - 1)) && half_r;

  always_comb begin
    unique case (mode_r) inside
      bmrd_pkg::MODE_ROW, bmrd_pkg::MODE_READ: report_row = a_r[bmrd_pkg::ROW_W-1:0];
      default:                                report_row = '0;
    endcase
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bmrd_pkg::S_IDLE: begin
        if (in_valid) begin
          if (bad_in) begin
            state_nxt = bmrd_pkg::S_COUNT;
          end else begin
            unique case (mode_in) inside
              bmrd_pkg::MODE_RECT:
                state_nxt = (in_arg_b == '0) ? bmrd_pkg::S_COUNT : bmrd_pkg::S_FILL;
              bmrd_pkg::MODE_ROW, bmrd_pkg::MODE_COL:
                state_nxt = bmrd_pkg::S_MOD;
              default:
                state_nxt = bmrd_pkg::S_COUNT;
            endcase
          end
        end
      end
      bmrd_pkg::S_MOD: begin
        if (!ge) begin
          state_nxt = (amt_r == '0) ? bmrd_pkg::S_COUNT : bmrd_pkg::S_ROT;
        end
      end
      bmrd_pkg::S_FILL: begin
        if (fill_last) begin
          state_nxt = bmrd_pkg::S_COUNT;
        end
      end
      bmrd_pkg::S_ROT: begin
        if (amt_r == bmrd_pkg::B_W'(1)) begin
          state_nxt = bmrd_pkg::S_COUNT;
        end
      end
      bmrd_pkg::S_COUNT: begin
        if (count_last) begin
          state_nxt = bmrd_pkg::S_DONE;
        end
      end
      bmrd_pkg::S_DONE: begin
        if (out_free) begin
          state_nxt = bmrd_pkg::S_IDLE;
        end
      end
      default: state_nxt = bmrd_pkg::S_IDLE;
    endcase
  end

  // Next values of the working registers
  always_comb begin
    mode_nxt = mode_r;
    a_nxt    = a_r;
    amt_nxt  = amt_r;
    bad_nxt  = bad_r;
    row_nxt  = row_r;
    half_nxt = half_r;
    case (state_r)
      bmrd_pkg::S_IDLE: begin
        if (in_valid) begin
          mode_nxt = mode_in;
          a_nxt    = in_arg_a;
          amt_nxt  = in_arg_b;
          bad_nxt  = bad_in;
          row_nxt  = '0;
          half_nxt = 1'b0;
        end
      end
      bmrd_pkg::S_MOD: begin
        if (ge) begin
          amt_nxt = diff;
        end
      end
      bmrd_pkg::S_ROT: begin
        amt_nxt = diff;
      end
      bmrd_pkg::S_FILL: begin
        row_nxt = fill_last ? '0 : row_r + bmrd_pkg::ROW_W'(1);
      end
      bmrd_pkg::S_COUNT: begin
        half_nxt = ~half_r;
        if (half_r) begin
          row_nxt = row_r + bmrd_pkg::ROW_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_ready        = (state_r == bmrd_pkg::S_IDLE);
    out_load        = (state_r == bmrd_pkg::S_DONE) && out_free;
    bad             = bad_r;
    store_ctl.op    = bmrd_pkg::ST_HOLD;
    store_ctl.row   = row_r;
    store_ctl.col   = a_r[bmrd_pkg::COL_IDX_W-1:0];
    store_ctl.width = a_r;
    count_ctl.clear = (state_r == bmrd_pkg::S_IDLE);
    count_ctl.add   = (state_r == bmrd_pkg::S_COUNT);
    count_ctl.half  = half_r;
    unique case (state_r)
      bmrd_pkg::S_FILL: begin
        store_ctl.op = bmrd_pkg::ST_FILL;
      end
      bmrd_pkg::S_ROT: begin
        store_ctl.op  = (mode_r == bmrd_pkg::MODE_ROW) ? bmrd_pkg::ST_ROT_ROW
                                                       : bmrd_pkg::ST_ROT_COL;
        store_ctl.row = a_r[bmrd_pkg::ROW_W-1:0];
      end
      bmrd_pkg::S_DONE: begin
        store_ctl.row = report_row;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bmrd_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r <= mode_nxt;
    a_r    <= a_nxt;
    amt_r  <= amt_nxt;
    bad_r  <= bad_nxt;
    row_r  <= row_nxt;
    half_r <= half_nxt;
  end

endmodule

@@ design/bmrd_chk.sv @@
`timescale 1ns / 1ps
`include "bit_matrix_rect_rotate_display_macros.svh"

module bmrd_chk (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [bmrd_pkg::ROW_BITS_W-1:0]   out_row_bits,
  input logic [bmrd_pkg::LIT_W-1:0]        out_lit_count,
  input logic                              out_bad_index
);

  // Stalled result holds
  `BMRD_CHK_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_row_bits) && $stable(out_lit_count), "stalled result changed")

  // Accepted item keeps the block busy
  `BMRD_CHK_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready right after accept")

  // Bad index reports a dark row
  `BMRD_CHK_NOW(a_bad_dark_row, out_valid && out_bad_index, out_row_bits == '0, "bad index with row bits")

  // Lit count never exceeds the matrix size
  `BMRD_CHK_NOW(a_count_range, out_valid, int'(out_lit_count) <= bmrd_pkg::ROWS * bmrd_pkg::COLS, "lit count out of range")

endmodule

bind bit_matrix_rect_rotate_display bmrd_chk u_bmrd_chk (.*);

@@ verif/tb.sv @@
`timescale 1ns / 1ps

module tb;

  localparam int IDLE_LIMIT = 3000;
  localparam int TAIL_CYCLES = 150;
  localparam int RANDOM_ITEMS = 500;

  typedef struct {
    logic [bmrd_pkg::ROW_BITS_W-1:0] row_bits;
    logic [bmrd_pkg::LIT_W-1:0]      lit_count;
    logic                            bad_index;
  } disp_result_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic [bmrd_pkg::MODE_W-1:0]     in_mode = '0;
  logic [bmrd_pkg::A_W-1:0]        in_arg_a = '0;
  logic [bmrd_pkg::B_W-1:0]        in_arg_b = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic [bmrd_pkg::ROW_BITS_W-1:0] out_row_bits;
  logic [bmrd_pkg::LIT_W-1:0]      out_lit_count;
  logic                            out_bad_index;

  // Shadow copy of the pixel store and the pending answers
  logic [bmrd_pkg::COLS-1:0] shadow_rows [bmrd_pkg::ROWS];
  disp_result_t              pending_answers[$];

  int mismatches = 0;
  int answers_seen = 0;
  int cmds_by_mode [4];
  int bad_cmds = 0;
  int idle_cycles = 0;
  bit no_gaps = 1'b0;
  bit sink_stalls = 1'b1;
  int stall_left = 0;

  bit_matrix_rect_rotate_display DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_mode       (in_mode),
    .in_arg_a      (in_arg_a),
    .in_arg_b      (in_arg_b),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_row_bits  (out_row_bits),
    .out_lit_count (out_lit_count),
    .out_bad_index (out_bad_index)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Count lit pixels across the shadow store
  function automatic int lit_total();
    int sum;
    sum = 0;
    for (int r = 0; r < bmrd_pkg::ROWS; r++) sum += $countones(shadow_rows[r]);
    return sum;
  endfunction

  // Apply one command to the shadow store and form its answer
  function automatic disp_result_t apply_command(bmrd_pkg::mode_t m,
                                                 logic [bmrd_pkg::A_W-1:0] a,
                                                 logic [bmrd_pkg::B_W-1:0] b);
    disp_result_t res;
    int w, h, s, rep;
    logic [bmrd_pkg::COLS-1:0] v, mask;
    logic moved [bmrd_pkg::ROWS];
    logic bad;
    bad = 1'b0;
    rep = 0;
    case (m)
      bmrd_pkg::MODE_RECT: begin
        w = (int'(a) > bmrd_pkg::COLS) ? bmrd_pkg::COLS : int'(a);
        h = (int'(b) > bmrd_pkg::ROWS) ? bmrd_pkg::ROWS : int'(b);
        mask = (w == 0) ? '0 : ({bmrd_pkg::COLS{1'b1}} >> (bmrd_pkg::COLS - w));
        for (int r = 0; r < h; r++) shadow_rows[r] |= mask;
      end
      bmrd_pkg::MODE_ROW: begin
        if (int'(a) < bmrd_pkg::ROWS) begin
          s = int'(b) % bmrd_pkg::COLS;
          v = shadow_rows[a[bmrd_pkg::ROW_W-1:0]];
          if (s != 0) v = (v << s) | (v >> (bmrd_pkg::COLS - s));
          shadow_rows[a[bmrd_pkg::ROW_W-1:0]] = v;
          rep = int'(a);
        end else begin
          bad = 1'b1;
        end
      end
      bmrd_pkg::MODE_COL: begin
        if (int'(a) < bmrd_pkg::COLS) begin
          s = int'(b) % bmrd_pkg::ROWS;
          for (int i = 0; i < bmrd_pkg::ROWS; i++)
            moved[(i + s) % bmrd_pkg::ROWS] = shadow_rows[i][a];
          for (int i = 0; i < bmrd_pkg::ROWS; i++) shadow_rows[i][a] = moved[i];
        end else begin
          bad = 1'b1;
        end
      end
      default: begin
        if (int'(a) < bmrd_pkg::ROWS) rep = int'(a);
        else bad = 1'b1;
      end
    endcase
    res.row_bits = bad ? '0 : shadow_rows[rep];
    res.lit_count = bmrd_pkg::LIT_W'(lit_total());
    res.bad_index = bad;
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  // Mostly short gaps, a few long ones, none during a burst
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(20, 80);
  endfunction

  // Drive one item and hold it until accepted, then record its answer
  task automatic send_cmd(input bmrd_pkg::mode_t m, input logic [bmrd_pkg::A_W-1:0] a,
                          input logic [bmrd_pkg::B_W-1:0] b);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_mode = m;
    in_arg_a = a;
    in_arg_b = b;
    do @(posedge clk); while (!in_ready);
    pending_answers.push_back(apply_command(m, a, b));
    cmds_by_mode[m]++;
    if ((m == bmrd_pkg::MODE_COL) ? (int'(a) >= bmrd_pkg::COLS)
                                  : (m != bmrd_pkg::MODE_RECT && int'(a) >= bmrd_pkg::ROWS))
      bad_cmds++;
  endtask

  task automatic wait_answers_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
  endtask

  // Receiver: random stalls, mostly short, some long
  always @(negedge clk) begin
    if (!sink_stalls) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 99) < 70) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= 1'b0;
      stall_left = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 3) : $urandom_range(20, 70);
    end
  end

  // Compare each answer with the oldest pending one
  always @(posedge clk) begin
    disp_result_t exp_res;
    if (rst_n && out_valid && out_ready) begin
      answers_seen++;
      if (pending_answers.size() == 0) begin
        report_mismatch("answer with nothing pending");
      end else begin
        exp_res = pending_answers.pop_front();
        if (out_row_bits !== exp_res.row_bits)
          report_mismatch($sformatf("row_bits got %h want %h", out_row_bits, exp_res.row_bits));
        if (out_lit_count !== exp_res.lit_count)
          report_mismatch($sformatf("lit_count got %0d want %0d", out_lit_count,
                                    exp_res.lit_count));
        if (out_bad_index !== exp_res.bad_index)
          report_mismatch($sformatf("bad_index got %b want %b", out_bad_index,
                                    exp_res.bad_index));
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
          $display("status: fail");
          $finish;
        end
      end
    end
  end

  // Read rows on a dark matrix, including out-of-range rows
  task automatic test_dark_after_reset();
    send_cmd(bmrd_pkg::MODE_READ, 6'd0, 8'd0);
    send_cmd(bmrd_pkg::MODE_READ, bmrd_pkg::A_W'(bmrd_pkg::ROWS - 1), 8'd255);
    send_cmd(bmrd_pkg::MODE_READ, bmrd_pkg::A_W'(bmrd_pkg::ROWS), 8'd0);
    send_cmd(bmrd_pkg::MODE_READ, 6'd63, 8'd0);
  endtask

  // Zero-size rects change nothing; small ones light the corner
  task automatic test_rect_edges();
    send_cmd(bmrd_pkg::MODE_RECT, 6'd0, 8'd5);
    send_cmd(bmrd_pkg::MODE_RECT, 6'd5, 8'd0);
    send_cmd(bmrd_pkg::MODE_RECT, 6'd1, 8'd1);
    send_cmd(bmrd_pkg::MODE_RECT, 6'd13, 8'd2);
  endtask

  // Row spins: zero, one, width-1, full width, large amount, bad rows
  task automatic test_row_spin();
    send_cmd(bmrd_pkg::MODE_ROW, 6'd0, 8'd1);
    send_cmd(bmrd_pkg::MODE_ROW, 6'd1, 8'd49);
    send_cmd(bmrd_pkg::MODE_ROW, 6'd0, 8'd50);
    send_cmd(bmrd_pkg::MODE_ROW, 6'd1, 8'd255);
    send_cmd(bmrd_pkg::MODE_ROW, bmrd_pkg::A_W'(bmrd_pkg::ROWS - 1), 8'd0);
    send_cmd(bmrd_pkg::MODE_ROW, bmrd_pkg::A_W'(bmrd_pkg::ROWS), 8'd3);
    send_cmd(bmrd_pkg::MODE_ROW, 6'd63, 8'd128);
  endtask

  // Column spins: modulo height, edge columns, bad columns
  task automatic test_column_spin();
    send_cmd(bmrd_pkg::MODE_COL, 6'd0, 8'd1);
    send_cmd(bmrd_pkg::MODE_COL, 6'd12, 8'd6);
    send_cmd(bmrd_pkg::MODE_COL, 6'd1, 8'd255);
    send_cmd(bmrd_pkg::MODE_COL, bmrd_pkg::A_W'(bmrd_pkg::COLS - 1), 8'd5);
    send_cmd(bmrd_pkg::MODE_COL, bmrd_pkg::A_W'(bmrd_pkg::COLS), 8'd2);
    send_cmd(bmrd_pkg::MODE_COL, 6'd63, 8'd7);
  endtask

  // Random mix; rects stay rare so the matrix does not saturate
  task automatic test_random_mix();
    int r;
    logic [bmrd_pkg::A_W-1:0] a;
    logic [bmrd_pkg::B_W-1:0] b;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 50 == 0) begin
        no_gaps = ($urandom_range(0, 3) == 0);
        sink_stalls = ($urandom_range(0, 3) != 0);
      end
      if (n % 125 == 124) wait_answers_drained();
      r = $urandom_range(0, 99);
      b = bmrd_pkg::B_W'($urandom_range(0, 255));
      if (r < 8 && lit_total() < 150) begin
        send_cmd(bmrd_pkg::MODE_RECT, bmrd_pkg::A_W'($urandom_range(0, 63)),
                 bmrd_pkg::B_W'($urandom_range(0, 3)));
      end else if (r < 45) begin
        a = ($urandom_range(0, 15) == 0) ? bmrd_pkg::A_W'($urandom_range(bmrd_pkg::ROWS, 63))
                                         : bmrd_pkg::A_W'($urandom_range(0, bmrd_pkg::ROWS - 1));
        send_cmd(bmrd_pkg::MODE_ROW, a, b);
      end else if (r < 82) begin
        a = ($urandom_range(0, 15) == 0) ? bmrd_pkg::A_W'($urandom_range(bmrd_pkg::COLS, 63))
                                         : bmrd_pkg::A_W'($urandom_range(0, bmrd_pkg::COLS - 1));
        send_cmd(bmrd_pkg::MODE_COL, a, b);
      end else begin
        a = ($urandom_range(0, 9) == 0) ? bmrd_pkg::A_W'($urandom_range(bmrd_pkg::ROWS, 63))
                                        : bmrd_pkg::A_W'($urandom_range(0, bmrd_pkg::ROWS - 1));
        send_cmd(bmrd_pkg::MODE_READ, a, b);
      end
    end
    no_gaps = 1'b0;
    sink_stalls = 1'b1;
  endtask

  // Oversized rect clamps to the full matrix
  task automatic test_full_clamp();
    send_cmd(bmrd_pkg::MODE_RECT, 6'd63, 8'd255);
    send_cmd(bmrd_pkg::MODE_READ, bmrd_pkg::A_W'(bmrd_pkg::ROWS - 1), 8'd0);
    send_cmd(bmrd_pkg::MODE_ROW, 6'd2, 8'd200);
    send_cmd(bmrd_pkg::MODE_RECT, bmrd_pkg::A_W'(bmrd_pkg::COLS),
             bmrd_pkg::B_W'(bmrd_pkg::ROWS));
  endtask

  initial begin
    for (int r = 0; r < bmrd_pkg::ROWS; r++) shadow_rows[r] = '0;
    for (int m = 0; m < 4; m++) cmds_by_mode[m] = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_dark_after_reset();
    test_rect_edges();
    test_row_spin();
    wait_answers_drained();
    test_column_spin();
    test_random_mix();
    test_full_clamp();

    wait_answers_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d rects, %0d row spins, %0d column spins, %0d reads (%0d bad index)",
             cmds_by_mode[bmrd_pkg::MODE_RECT], cmds_by_mode[bmrd_pkg::MODE_ROW],
             cmds_by_mode[bmrd_pkg::MODE_COL], cmds_by_mode[bmrd_pkg::MODE_READ], bad_cmds);
    $display("checked %0d answers, %0d mismatches", answers_seen, mismatches);
    if (mismatches == 0 && pending_answers.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
